// File: design/assert_macros.svh
// Assertion macros shared by the RTL. Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a clocked property; skipped while reset is high.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that a condition never holds at a clock edge.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

// File: design/sobel_pkg.sv
`timescale 1ns / 1ps

package sobel_pkg;

   localparam int MAX_WIDTH_DEFAULT  = 1024;
   localparam int FRAME_WIDTH_RESET  = 512;
   localparam int FRAME_HEIGHT_RESET = 512;
   localparam int MIN_DIM            = 2;

   localparam int PIX_W        = 8;
   localparam int CFG_WIDTH_W  = 11;
   localparam int CFG_HEIGHT_W = 16;
   localparam int ROW_W        = CFG_HEIGHT_W + 1;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 16;

   localparam int ROOT_STEPS = 8;
   localparam int STEP_W     = 3;

   localparam logic [PIX_W-1:0] MAG_MAX = 8'd255;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   localparam logic ACTION_PIXEL = 1'b0;
   localparam logic ACTION_DRAIN = 1'b1;

   typedef struct packed {
      logic             action;
      logic [PIX_W-1:0] pixel_value;
   } req_item_type;

   typedef struct packed {
      logic [PIX_W-1:0] edge_magnitude;
      logic             frame_last;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_GRAD,
      ST_SQUARE,
      ST_ROOT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic advance;
      logic grad_load;
      logic grad_post;
      logic square_load;
      logic root_step;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic item_useful;
      logic pre_needed;
      logic post_needed;
      logic root_last;
      logic out_free;
   } dp_status_type;

endpackage

// File: design/sobel_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sobel_ctrl import sobel_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            // drop items that do nothing in this phase of the frame
            if (req_valid && status.item_useful) begin
               cmd.capture = 1'b1;
               state_in    = ST_FETCH;
            end
         end
         ST_FETCH: begin
            cmd.advance = 1'b1;
            if (status.pre_needed) begin
               cmd.grad_load = 1'b1;
               state_in      = ST_SQUARE;
            end else if (status.post_needed) begin
               state_in = ST_GRAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_GRAD: begin
            cmd.grad_load = 1'b1;
            cmd.grad_post = 1'b1;
            state_in      = ST_SQUARE;
         end
         ST_SQUARE: begin
            cmd.square_load = 1'b1;
            state_in        = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            if (status.root_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `ASSERT_PROP(a_root_holds, clock, reset, state_ff == ST_ROOT && !status.root_last |=> state_ff == ST_ROOT, "root iteration left early")
   `ASSERT_PROP(a_capture_stalls, clock, reset, cmd.capture |=> req_stall, "input taken while busy")
   `ASSERT_NEVER(a_one_result, clock, reset, state_ff == ST_FETCH && status.pre_needed && status.post_needed, "two results from one item")

endmodule

// File: design/sobel_datapath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sobel_datapath import sobel_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  req_item_type           req_item,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  dp_cmd_type             cmd,
   output dp_status_type          status,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_item_type           rsp_item
);

   localparam int COL_W       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CNT_W       = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W       = (CNT_W > CFG_WIDTH_W) ? CNT_W : CFG_WIDTH_W;
   localparam int WIDTH_RESET = (FRAME_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                                : FRAME_WIDTH_RESET;
   localparam int GRAD_W      = 11;
   localparam int SUM_W       = 10;
   localparam int RES_W       = 17;

   typedef struct packed {
      logic drain_end;
      logic mirror_row;
      logic pre_needed;
      logic post_needed;
      logic top_pre;
      logic top_post;
      logic left_post;
   } item_flags_type;

   // frame geometry and position
   logic [CNT_W-1:0]        width_ff;
   logic [CNT_W-1:0]        width_in;
   logic [CFG_HEIGHT_W-1:0] height_ff;
   logic [CFG_HEIGHT_W-1:0] height_in;
   logic [COL_W-1:0]        col_ff;
   logic [COL_W-1:0]        col_in;
   logic [ROW_W-1:0]        row_ff;
   logic [ROW_W-1:0]        row_in;
   logic                    csr_write;
   logic [CMP_W-1:0]        fw_ext;
   logic [CNT_W-1:0]        col_sum;
   logic [ROW_W-1:0]        height_ext;

   // item capture
   item_flags_type          flags_ff;
   item_flags_type          flags_in;
   logic [PIX_W-1:0]        pix_ff;
   logic                    at_drain_row;
   logic                    at_mirror_row;
   logic                    item_useful;

   // line store: older row in the upper half, newer row in the lower half
   logic [2*PIX_W-1:0]      line_mem [MAX_WIDTH];
   logic [2*PIX_W-1:0]      rd_ff;
   logic [PIX_W-1:0]        rd_older;
   logic [PIX_W-1:0]        rd_newer;
   logic [PIX_W-1:0]        pix_new;

   logic [PIX_W-1:0]        win_ff [3][3];

   // gradient and magnitude
   logic [1:0]              l_idx;
   logic [1:0]              c_idx;
   logic [1:0]              r_idx;
   logic                    top_mirror;
   logic [PIX_W-1:0]        t_l, t_c, t_r, m_l, m_r, b_l, b_c, b_r;
   logic [SUM_W-1:0]        sum_right, sum_left, sum_bottom, sum_top;
   logic signed [GRAD_W-1:0] gx_in, gy_in;
   logic signed [GRAD_W-1:0] gx_ff, gy_ff;
   logic [GRAD_W-1:0]       ax, ay;
   logic [2*PIX_W-1:0]      sq_x, sq_y;
   logic [2*PIX_W:0]        sq_sum;
   logic                    sat_ff;
   logic [2*PIX_W-1:0]      rem_ff;
   logic [RES_W-1:0]        res_ff;
   logic [STEP_W-1:0]       step_ff;
   logic [RES_W-1:0]        root_bit;
   logic [RES_W-1:0]        root_trial;

   logic                    rsp_valid_ff;
   rsp_item_type            rsp_item_ff;

   function automatic logic [SUM_W-1:0] tap_sum(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b,
                                                 input logic [PIX_W-1:0] c);
      tap_sum = SUM_W'(a) + {1'b0, b, 1'b0} + SUM_W'(c);
   endfunction

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // clamp the register values on write
   always_comb begin
      fw_ext = CMP_W'(csr_data[CFG_WIDTH_W-1:0]);
      priority if (fw_ext < CMP_W'(MIN_DIM)) begin
         width_in = CNT_W'(MIN_DIM);
      end else if (fw_ext > CMP_W'(MAX_WIDTH)) begin
         width_in = CNT_W'(MAX_WIDTH);
      end else begin
         width_in = CNT_W'(fw_ext);
      end
      if (csr_data[CFG_HEIGHT_W-1:0] < CFG_HEIGHT_W'(MIN_DIM)) begin
         height_in = CFG_HEIGHT_W'(MIN_DIM);
      end else begin
         height_in = csr_data[CFG_HEIGHT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CNT_W'(WIDTH_RESET);
         height_ff <= CFG_HEIGHT_W'(FRAME_HEIGHT_RESET);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  width_ff  <= width_in;
            CSR_FRAME_HEIGHT: height_ff <= height_in;
         endcase
      end
   end

   // classify the offered item against the frame position
   always_comb begin
      height_ext    = {1'b0, height_ff};
      at_drain_row  = row_ff == height_ext + ROW_W'(1);
      at_mirror_row = row_ff == height_ext;
      priority if (at_drain_row) begin
         item_useful = req_item.action == ACTION_DRAIN;
      end else if (at_mirror_row) begin
         item_useful = req_item.action == ACTION_DRAIN;
      end else begin
         item_useful = req_item.action == ACTION_PIXEL;
      end
      flags_in.drain_end   = at_drain_row;
      flags_in.mirror_row  = at_mirror_row;
      flags_in.pre_needed  = at_drain_row
                             || (col_ff == '0 && row_ff >= ROW_W'(2));
      flags_in.post_needed = !at_drain_row && col_ff != '0 && row_ff != '0;
      flags_in.top_pre     = row_ff == ROW_W'(2);
      flags_in.top_post    = row_ff == ROW_W'(1);
      flags_in.left_post   = col_ff == COL_W'(1);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         flags_ff <= flags_in;
         pix_ff   <= req_item.pixel_value;
      end
   end

   // line store: read on capture, write back on advance
   assign rd_older = rd_ff[2*PIX_W-1:PIX_W];
   assign rd_newer = rd_ff[PIX_W-1:0];
   assign pix_new  = flags_ff.mirror_row ? rd_older : pix_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_ff <= line_mem[col_ff];
      end
      if (cmd.advance && !flags_ff.drain_end) begin
         line_mem[col_ff] <= {rd_newer, pix_new};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.advance && !flags_ff.drain_end) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2] <= rd_older;
         win_ff[1][2] <= rd_newer;
         win_ff[2][2] <= pix_new;
      end
   end

   // advance the raster position
   always_comb begin
      col_sum = CNT_W'(col_ff) + CNT_W'(1);
      col_in  = col_ff;
      row_in  = row_ff;
      if (csr_write) begin
         col_in = '0;
         row_in = '0;
      end else if (cmd.advance) begin
         if (flags_ff.drain_end) begin
            col_in = '0;
            row_in = '0;
         end else if (col_sum == width_ff) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = COL_W'(col_sum);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // gradients from the selected window taps
   always_comb begin
      if (cmd.grad_post) begin
         l_idx      = flags_ff.left_post ? 2'd2 : 2'd0;
         c_idx      = 2'd1;
         r_idx      = 2'd2;
         top_mirror = flags_ff.top_post;
      end else begin
         l_idx      = 2'd1;
         c_idx      = 2'd2;
         r_idx      = 2'd1;
         top_mirror = flags_ff.top_pre;
      end
      t_l = top_mirror ? win_ff[2][l_idx] : win_ff[0][l_idx];
      t_c = top_mirror ? win_ff[2][c_idx] : win_ff[0][c_idx];
      t_r = top_mirror ? win_ff[2][r_idx] : win_ff[0][r_idx];
      m_l = win_ff[1][l_idx];
      m_r = win_ff[1][r_idx];
      b_l = win_ff[2][l_idx];
      b_c = win_ff[2][c_idx];
      b_r = win_ff[2][r_idx];
      sum_right  = tap_sum(t_r, m_r, b_r);
      sum_left   = tap_sum(t_l, m_l, b_l);
      sum_bottom = tap_sum(b_l, b_c, b_r);
      sum_top    = tap_sum(t_l, t_c, t_r);
      gx_in = $signed({1'b0, sum_right}) - $signed({1'b0, sum_left});
      gy_in = $signed({1'b0, sum_bottom}) - $signed({1'b0, sum_top});
   end

   always_ff @(posedge clock) begin
      if (cmd.grad_load) begin
         gx_ff <= gx_in;
         gy_ff <= gy_in;
      end
   end

   // squares; any component of 256 or more, or a sum of 65536 or more, saturates
   always_comb begin
      ax     = gx_ff[GRAD_W-1] ? $unsigned(-gx_ff) : $unsigned(gx_ff);
      ay     = gy_ff[GRAD_W-1] ? $unsigned(-gy_ff) : $unsigned(gy_ff);
      sq_x   = ax[PIX_W-1:0] * ax[PIX_W-1:0];
      sq_y   = ay[PIX_W-1:0] * ay[PIX_W-1:0];
      sq_sum = {1'b0, sq_x} + {1'b0, sq_y};
   end

   // integer root, one result bit per step
   assign root_bit   = RES_W'(1) << {step_ff, 1'b0};
   assign root_trial = res_ff + root_bit;

   always_ff @(posedge clock) begin
      if (cmd.square_load) begin
         sat_ff  <= (|ax[GRAD_W-1:PIX_W]) || (|ay[GRAD_W-1:PIX_W]) || sq_sum[2*PIX_W];
         rem_ff  <= sq_sum[2*PIX_W-1:0];
         res_ff  <= '0;
         step_ff <= STEP_W'(ROOT_STEPS - 1);
      end else if (cmd.root_step) begin
         if (RES_W'(rem_ff) >= root_trial) begin
            rem_ff <= rem_ff - root_trial[2*PIX_W-1:0];
            res_ff <= (res_ff >> 1) + root_bit;
         end else begin
            res_ff <= res_ff >> 1;
         end
         step_ff <= step_ff - STEP_W'(1);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_item_ff.edge_magnitude <= sat_ff ? MAG_MAX : res_ff[PIX_W-1:0];
         rsp_item_ff.frame_last     <= flags_ff.drain_end;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   always_comb begin
      status.item_useful = item_useful;
      status.pre_needed  = flags_ff.pre_needed;
      status.post_needed = flags_ff.post_needed;
      status.root_last   = step_ff == '0;
      status.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   `ASSERT_PROP(a_col_in_row, clock, reset,
                CNT_W'(col_ff) < width_ff, "column past row width")
   `ASSERT_PROP(a_row_in_frame, clock, reset,
                row_ff <= ({1'b0, height_ff} + ROW_W'(1)), "row past drain row")
   `ASSERT_PROP(a_no_overwrite, clock, reset,
                cmd.out_load |-> !rsp_valid_ff || !rsp_stall, "pending result overwritten")

endmodule

// File: design/sobel_edge_magnitude_3x3_unit.sv
`timescale 1ns / 1ps
// 3x3 Sobel gradient magnitude over a raster pixel stream.
// req_* carries items: action 0 with pixel_value is a pixel, action 1 is a
// drain item; send frame_width+1 drain items after each frame's last pixel.
// Items that do not fit the current phase of the frame are accepted and
// dropped. rsp_* carries edge_magnitude, with frame_last set on the final
// result of the frame. Results lag the pixels by one row plus one pixel.
// csr_* writes frame_width (index 0) and frame_height (index 1); csr_ready
// is always high, and a write restarts the frame. Write only while idle.
// One item is worked on at a time, and no new item is taken before the last
// is through: a kept item gets the line-store read and write-back, and one
// with a result also the gradient, square and 8-step square-root loop.
// A finished result waits in the output register while the next item is
// taken; a stalled receiver holds rsp_* and stalls the block only when a
// second result is ready. Synchronous reset restores 512x512 geometry and
// the frame start; line store contents are not cleared.
module sobel_edge_magnitude_3x3_unit import sobel_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_item_type           req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_item_type           rsp_item,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencing of one item: capture, fetch, gradient, square, root, deliver
   sobel_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // line store, window, arithmetic and the output register
   sobel_datapath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

// File: tb/tb_sobel_edge_magnitude_3x3_unit.sv
`timescale 1ns / 1ps

module tb_sobel_edge_magnitude_3x3_unit;
   import sobel_pkg::*;

   localparam int MAX_W          = MAX_WIDTH_DEFAULT;
   localparam int SETTLE_CYCLES  = 20;    // covers the longest per-item work of the block
   localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
   localparam int WATCHDOG_LIMIT = 4000;  // cycles without any handshake
   localparam int RANDOM_ITEMS   = 160;
   localparam logic [PIX_W-1:0] PIX_FULL = 8'hFF;

   typedef enum int {
      PAT_NOISE,
      PAT_RAMP,
      PAT_BINARY,
      PAT_FLAT
   } pixel_pattern_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_item_type           req_item;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_item_type           rsp_item;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   sobel_edge_magnitude_3x3_unit #(
      .MAX_WIDTH(MAX_W)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item(rsp_item),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // Shared run state.
   rsp_item_type expected_edges[$];
   int  failures     = 0;
   int  useful_items = 0;
   int  quiet_cycles = 0;
   int  hold_len     = 0;   // receiver hold-off, counted down by the stall process
   bit  calm         = 0;   // no idling on either side while set, but for a counted receiver hold-off
   int  ramp_base, ramp_dx, ramp_dy;

   // Predictor state: line stores, window, frame position and geometry.
   logic [PIX_W-1:0]        older_line [MAX_W];
   logic [PIX_W-1:0]        newer_line [MAX_W];
   logic [PIX_W-1:0]        win [9];
   int                      col_pos;
   int                      row_pos;
   logic [CFG_WIDTH_W-1:0]  width_reg;
   logic [CFG_HEIGHT_W-1:0] height_reg;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   function automatic void restart_frame_pos();
      col_pos = 0;
      row_pos = 0;
      for (int i = 0; i < 9; i++) win[i] = '0;
   endfunction

   function automatic void reset_prediction();
      for (int i = 0; i < MAX_W; i++) begin
         older_line[i] = '0;
         newer_line[i] = '0;
      end
      width_reg  = CFG_WIDTH_W'(FRAME_WIDTH_RESET);
      height_reg = CFG_HEIGHT_W'(FRAME_HEIGHT_RESET);
      restart_frame_pos();
   endfunction

   // Gradient magnitude from window rows (top, mid, bottom) and chosen columns.
   function automatic logic [PIX_W-1:0] sobel_mag(input int top, input int l, input int c,
                                                  input int r);
      int gx, gy, sum, root, trial;
      gx = (int'(win[top*3+r]) + 2 * int'(win[3+r]) + int'(win[6+r]))
         - (int'(win[top*3+l]) + 2 * int'(win[3+l]) + int'(win[6+l]));
      gy = (int'(win[6+l]) + 2 * int'(win[6+c]) + int'(win[6+r]))
         - (int'(win[top*3+l]) + 2 * int'(win[top*3+c]) + int'(win[top*3+r]));
      sum = gx * gx + gy * gy;
      if (sum >= 65536) return MAG_MAX;
      // Bitwise integer root: build the largest value whose square fits.
      root = 0;
      for (int b = PIX_W - 1; b >= 0; b--) begin
         trial = root | (1 << b);
         if (trial * trial <= sum) root = trial;
      end
      return PIX_W'(root);
   endfunction

   function automatic void push_edge(input logic [PIX_W-1:0] mag, input logic last);
      rsp_item_type it;
      it.edge_magnitude = mag;
      it.frame_last     = last;
      expected_edges.push_back(it);
   endfunction

   // Advance the predictor by one accepted item; return 1 unless it is dropped.
   function automatic bit predict_edges(input req_item_type it);
      int w, h, x, y;
      logic [PIX_W-1:0] p;
      w = int'(width_reg);
      h = int'(height_reg);
      if (w < MIN_DIM) w = MIN_DIM;
      if (w > MAX_W) w = MAX_W;
      if (h < MIN_DIM) h = MIN_DIM;
      x = col_pos;
      y = row_pos;
      p = it.pixel_value;
      if (x >= w) x = 0;

      // Final drain item: emit the frame's last result and start over.
      if (y == h + 1) begin
         if (it.action != ACTION_DRAIN) return 0;
         push_edge(sobel_mag((y == 2) ? 2 : 0, 1, 2, 1), 1'b1);
         restart_frame_pos();
         return 1;
      end
      // Drain row: mirror the bottom border by replaying row h-2.
      if (y == h) begin
         if (it.action != ACTION_DRAIN) return 0;
         p = older_line[x];
      end else if (it.action != ACTION_PIXEL) begin
         return 0;
      end

      // Row start: finish the previous row's last pixel, right side mirrored.
      if (x == 0 && y >= 2) push_edge(sobel_mag((y == 2) ? 2 : 0, 1, 2, 1), 1'b0);

      for (int k = 0; k < 3; k++) begin
         win[k*3]   = win[k*3+1];
         win[k*3+1] = win[k*3+2];
      end
      win[2] = older_line[x];
      win[5] = newer_line[x];
      win[8] = p;
      older_line[x] = newer_line[x];
      newer_line[x] = p;

      if (x >= 1 && y >= 1)
         push_edge(sobel_mag((y == 1) ? 2 : 0, (x == 1) ? 2 : 0, 1, 2), 1'b0);

      x++;
      if (x == w) begin
         x = 0;
         y++;
      end
      col_pos = x;
      row_pos = y;
      return 1;
   endfunction

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------

   // Idle length: mostly short, now and then long.
   function automatic int gap_length();
      if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Offer one item, hold it until accepted, then predict its results.
   task automatic send_item(input logic act, input logic [PIX_W-1:0] pix);
      req_item_type it;
      int gap;
      bit useful;
      it.action      = act;
      it.pixel_value = pix;
      gap = (calm || $urandom_range(0, 99) < 65) ? 0 : gap_length();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (req_stall);
      useful = predict_edges(it);
      if (useful) useful_items++;
   endtask

   // Write one register; only called while the block is idle.
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_FRAME_WIDTH) width_reg = data[CFG_WIDTH_W-1:0];
      else height_reg = data[CFG_HEIGHT_W-1:0];
      restart_frame_pos();
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Drop valid, wait for every expected result, then let the block settle.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_edges.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic choose_ramp();
      ramp_base = $urandom_range(0, 255);
      ramp_dx   = $urandom_range(0, 12);
      ramp_dy   = $urandom_range(0, 12);
   endtask

   function automatic logic [PIX_W-1:0] pick_pixel(input pixel_pattern_type pattern,
                                                   input int x, input int y);
      case (pattern)
         PAT_RAMP:   return PIX_W'(ramp_base + x * ramp_dx + y * ramp_dy);
         PAT_BINARY: return $urandom_range(0, 1) ? PIX_FULL : '0;
         PAT_FLAT:   return PIX_W'(ramp_base + $urandom_range(0, 3));
         default:    return PIX_W'($urandom);
      endcase
   endfunction

   // Send a frame of w x h pixels plus w+1 drain items; stray items are mixed
   // in at noise_pct percent. Stop early after stop_after pixels when >= 0.
   task automatic send_frame(input int w, input int h, input pixel_pattern_type pattern,
                             input int noise_pct, input int stop_after);
      int n;
      n = 0;
      for (int y = 0; y < h; y++) begin
         for (int x = 0; x < w; x++) begin
            if (n == stop_after) return;
            if ($urandom_range(0, 99) < noise_pct) send_item(ACTION_DRAIN, PIX_W'($urandom));
            send_item(ACTION_PIXEL, pick_pixel(pattern, x, y));
            n++;
         end
      end
      for (int k = 0; k <= w; k++) begin
         if ($urandom_range(0, 99) < noise_pct) send_item(ACTION_PIXEL, PIX_W'($urandom));
         send_item(ACTION_DRAIN, PIX_W'($urandom));
      end
   endtask

   // ------------------------------------------------------------------
   // Receiver: random stall runs, a counted hold-off when requested
   // ------------------------------------------------------------------

   initial begin
      int  run;
      bit  level;
      rsp_stall = 1'b0;
      run   = 0;
      level = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_len > 0) begin
            hold_len = hold_len - 1;
            rsp_stall <= 1'b1;
         end else if (calm) begin
            run = 0;
            rsp_stall <= 1'b0;
         end else begin
            if (run == 0) begin
               level = ($urandom_range(0, 99) < 30);
               run   = level ? gap_length() : $urandom_range(1, 12);
            end
            run--;
            rsp_stall <= level;
         end
      end
   end

   // ------------------------------------------------------------------
   // Result checker and watchdog
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_edges.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual magnitude %0d last %0b",
                     $time, rsp_item.edge_magnitude, rsp_item.frame_last);
            failures++;
         end else begin
            want = expected_edges.pop_front();
            if (rsp_item.edge_magnitude !== want.edge_magnitude) begin
               $display("%0t: edge_magnitude mismatch, expected %0d actual %0d",
                        $time, want.edge_magnitude, rsp_item.edge_magnitude);
               failures++;
            end
            if (rsp_item.frame_last !== want.frame_last) begin
               $display("%0t: frame_last mismatch, expected %0b actual %0b",
                        $time, want.frame_last, rsp_item.frame_last);
               failures++;
            end
         end
      end
   end

   // End the run when no handshake of any kind happens for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d results outstanding",
                     $time, WATCHDOG_LIMIT, expected_edges.size());
            $display("tb: failure");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset geometry is 512 wide: results first show up on the second row.
   task automatic test_reset_geometry();
      send_frame(FRAME_WIDTH_RESET, FRAME_HEIGHT_RESET, PAT_NOISE, 0, FRAME_WIDTH_RESET + 3);
      wait_drained();
   endtask

   // Below-minimum registers act as 2x2; stray drain and stray pixel are dropped.
   task automatic test_smallest_frames();
      write_csr(CSR_FRAME_WIDTH, 16'd0);
      write_csr(CSR_FRAME_HEIGHT, 16'd1);
      send_item(ACTION_PIXEL, 8'd0);
      send_item(ACTION_DRAIN, 8'd0);      // drain during the frame
      send_item(ACTION_PIXEL, PIX_FULL);
      send_item(ACTION_PIXEL, PIX_FULL);
      send_item(ACTION_PIXEL, 8'd0);
      send_item(ACTION_PIXEL, 8'd77);     // pixel during the drain
      repeat (3) send_item(ACTION_DRAIN, PIX_FULL);
      wait_drained();

      write_csr(CSR_FRAME_WIDTH, 16'd1);
      write_csr(CSR_FRAME_HEIGHT, 16'd0);
      send_item(ACTION_DRAIN, PIX_FULL);  // next frame already begun
      repeat (4) send_item(ACTION_PIXEL, PIX_FULL);
      repeat (3) send_item(ACTION_DRAIN, 8'd0);
      wait_drained();
   endtask

   // Hard vertical edge (saturates) next to gentle rows (exact root).
   task automatic test_vertical_edge();
      logic [PIX_W-1:0] pix [12];
      pix = '{8'd0, 8'd0, 8'd255, 8'd255,
              8'd10, 8'd20, 8'd30, 8'd40,
              8'd5, 8'd5, 8'd5, 8'd5};
      write_csr(CSR_FRAME_WIDTH, 16'd4);
      write_csr(CSR_FRAME_HEIGHT, 16'd3);
      for (int i = 0; i < 12; i++) send_item(ACTION_PIXEL, pix[i]);
      repeat (5) send_item(ACTION_DRAIN, 8'd0);
      wait_drained();
   endtask

   // Tallest height: run part of a frame, then restart it with a write.
   task automatic test_tall_frame();
      choose_ramp();
      write_csr(CSR_FRAME_WIDTH, 16'd2);
      write_csr(CSR_FRAME_HEIGHT, 16'hFFFF);
      send_frame(2, 65535, PAT_RAMP, 0, 30);
      wait_drained();
      write_csr(CSR_FRAME_WIDTH, 16'd3);
      send_frame(3, 65535, PAT_NOISE, 5, 12);
      wait_drained();
   endtask

   // Oversized width acts as the full line store; stop a few pixels into the
   // second row, past the wrap of the last column.
   task automatic test_widest_row();
      write_csr(CSR_FRAME_WIDTH, 16'h07FF);
      write_csr(CSR_FRAME_HEIGHT, 16'd2);
      send_frame(MAX_W, 2, PAT_NOISE, 0, MAX_W + 4);
      wait_drained();
   endtask

   // Hold the receiver off while items keep coming so the block backs up,
   // then pause the sender mid-frame until every result is out.
   task automatic test_result_backlog();
      write_csr(CSR_FRAME_WIDTH, 16'd6);
      write_csr(CSR_FRAME_HEIGHT, 16'd4);
      calm     = 1'b1;
      hold_len = HOLD_CYCLES;
      for (int n = 0; n < 24; n++) begin
         if (n == 15) begin
            calm = 1'b0;
            wait_drained();
         end
         send_item(ACTION_PIXEL, PIX_W'($urandom));
      end
      repeat (7) send_item(ACTION_DRAIN, PIX_W'($urandom));
      wait_drained();
   endtask

   // Mostly whole frames of random geometry and content, some cut short,
   // some pure noise.
   task automatic test_random_frames();
      int start, w, h, ew, eh, r;
      pixel_pattern_type pattern;
      start = useful_items;
      while (useful_items - start < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 5) w = $urandom_range(0, 1);
         else if (r < 75) w = $urandom_range(2, 10);
         else if (r < 97) w = $urandom_range(11, 40);
         else w = $urandom_range(41, 128);
         r = $urandom_range(0, 99);
         if (r < 5) h = $urandom_range(0, 1);
         else if (r < 85) h = $urandom_range(2, 5);
         else h = $urandom_range(6, 10);
         if ($urandom_range(0, 1)) begin
            write_csr(CSR_FRAME_WIDTH, CSR_DATA_W'(w));
            write_csr(CSR_FRAME_HEIGHT, CSR_DATA_W'(h));
         end else begin
            write_csr(CSR_FRAME_HEIGHT, CSR_DATA_W'(h));
            write_csr(CSR_FRAME_WIDTH, CSR_DATA_W'(w));
         end
         ew = (w < MIN_DIM) ? MIN_DIM : w;
         eh = (h < MIN_DIM) ? MIN_DIM : h;
         calm    = ($urandom_range(0, 99) < 15);
         pattern = pixel_pattern_type'($urandom_range(PAT_NOISE, PAT_FLAT));
         choose_ramp();
         r = $urandom_range(0, 99);
         if (r < 85) begin
            send_frame(ew, eh, pattern, 3, -1);
         end else if (r < 95) begin
            send_frame(ew, eh, pattern, 3, $urandom_range(1, ew * eh - 1));
         end else begin
            repeat ($urandom_range(5, 30))
               send_item(logic'($urandom_range(0, 1)), PIX_W'($urandom));
         end
         calm = 1'b0;
         wait_drained();
      end
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_item  = '0;
      csr_valid = 1'b0;
      csr_index = CSR_FRAME_WIDTH;
      csr_data  = '0;
      reset_prediction();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_geometry();
      test_smallest_frames();
      test_vertical_edge();
      test_tall_frame();
      test_widest_row();
      test_result_backlog();
      test_random_frames();

      if (failures == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
